[rtl/core/csc_pkg.sv]
// Shared types, codes and constant-divide helpers for the clock/stopwatch controller.
package csc_pkg;

  // Top row display mode
  typedef enum logic [1:0] {
    DISP_VOLTS = 2'd0,
    DISP_FAHR  = 2'd1,
    DISP_CELS  = 2'd2
  } csc_disp_t;

  // Clock row mode
  typedef enum logic [1:0] {
    CLK_UTC     = 2'd0,
    CLK_LOCAL   = 2'd1,
    CLK_FLIGHT  = 2'd2,
    CLK_ELAPSED = 2'd3
  } csc_clk_t;

  // Configuration register indexes
  localparam logic CFG_HOLD_RESET  = 1'b0;
  localparam logic CFG_TEMP_SAMPLE = 1'b1;

  localparam logic [3:0] HOLD_RESET_DEFAULT  = 4'd1;
  localparam logic [5:0] TEMP_SAMPLE_DEFAULT = 6'd4;

  typedef struct packed {
    logic [3:0] hold_reset;
    logic [5:0] temp_sample;
  } csc_cfg_t;

  // One registered panel update
  typedef struct packed {
    logic [31:0] now_s;
    logic [16:0] utc_s;
    logic [16:0] loc_s;
    logic [9:0]  volts;
    logic [10:0] temp;
    logic        top_chg;
    logic        top_lvl;
    logic        left_chg;
    logic        left_lvl;
    logic        right_chg;
    logic        right_lvl;
  } csc_item_t;

  // What the formatter needs after the button/state pass
  typedef struct packed {
    csc_disp_t   disp_mode;
    csc_clk_t    clk_mode;
    logic        running;
    logic [9:0]  volts;
    logic [10:0] temp;
    logic [31:0] tval;
  } csc_view_t;

  // One result transfer
  typedef struct packed {
    csc_disp_t  disp_mode;
    csc_clk_t   clk_mode;
    logic [4:0] top_hundreds;
    logic [3:0] top_tens;
    logic [3:0] top_units;
    logic       top_minus;
    logic [3:0] digit_a;
    logic [3:0] digit_b;
    logic [3:0] digit_c;
    logic [3:0] digit_d;
    logic       running;
  } csc_res_t;

  // x / 60 for 32-bit x: (x >> 2) / 15 by reciprocal, exact for x < 2^32
  function automatic logic [26:0] div60_32(input logic [31:0] x);
    logic [60:0] p;
    p = {31'b0, x[31:2]} * 61'd1145324613;
    return p[60:34];
  endfunction

  // x / 60 for 27-bit x
  function automatic logic [20:0] div60_27(input logic [26:0] x);
    logic [50:0] p;
    p = {26'b0, x[26:2]} * 51'd35791395;
    return p[49:29];
  endfunction

  // x / 99 for 27-bit x
  function automatic logic [19:0] div99_27(input logic [26:0] x);
    logic [54:0] p;
    p = {28'b0, x} * 55'd173534033;
    return p[53:34];
  endfunction

  // x / 24 for 21-bit x: (x >> 3) / 3
  function automatic logic [15:0] div24_21(input logic [20:0] x);
    logic [35:0] p;
    p = {18'b0, x[20:3]} * 36'd174763;
    return p[34:19];
  endfunction

  // x / 10 for 15-bit x: (x >> 1) / 5
  function automatic logic [11:0] div10_15(input logic [14:0] x);
    logic [27:0] p;
    p = {14'b0, x[14:1]} * 28'd13108;
    return p[27:16];
  endfunction

  // Two decimal digits {tens, units} of a value below 100
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [11:0] q;
    logic [6:0]  t;
    q = div10_15({8'b0, v});
    t = ({3'b0, q[3:0]} << 3) + ({3'b0, q[3:0]} << 1);
    return {q[3:0], 4'(v - t)};
  endfunction

endpackage

[rtl/core/csc_ctrl.sv]
// Button, stopwatch, hold and temperature-sample state with the first result stage.
module csc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               adv,
  input  csc_pkg::csc_cfg_t  cfg,
  input  csc_pkg::csc_item_t item,
  output csc_pkg::csc_view_t view
);
  import csc_pkg::*;

  csc_disp_t   disp_r, disp_nxt;
  csc_clk_t    clk_mode_r, clk_mode_nxt;
  logic        top_prev_r, top_prev_nxt;
  logic        left_prev_r, left_prev_nxt;
  logic        right_prev_r, right_prev_nxt;
  logic        running_r, running_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [31:0] start_r, start_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] since_r, since_nxt;
  logic [31:0] flight_r, flight_nxt;
  logic [31:0] last_temp_r, last_temp_nxt;
  logic [10:0] held_r, held_nxt;

  logic [31:0] elapsed_sum;
  logic        watch_clr;
  logic [31:0] tval;
  csc_view_t   view_r;

  // Button events, then the shown clock value from the updated state
  always_comb begin
    disp_nxt       = disp_r;
    clk_mode_nxt   = clk_mode_r;
    top_prev_nxt   = top_prev_r;
    left_prev_nxt  = left_prev_r;
    right_prev_nxt = right_prev_r;
    running_nxt    = running_r;
    accum_nxt      = accum_r;
    start_nxt      = start_r;
    armed_nxt      = armed_r;
    since_nxt      = since_r;
    flight_nxt     = flight_r;
    last_temp_nxt  = last_temp_r;
    held_nxt       = held_r;
    watch_clr      = 1'b0;

    // accumulated time plus the running span; also the total on a stop
    elapsed_sum = accum_r + (running_r ? (item.now_s - start_r) : 32'd0);

    if (item.top_chg) begin
      if (top_prev_r) begin
        case (disp_r)
          DISP_VOLTS: disp_nxt = DISP_FAHR;
          DISP_FAHR:  disp_nxt = DISP_CELS;
          default:    disp_nxt = DISP_VOLTS;
        endcase
      end
      top_prev_nxt = item.top_lvl;
    end

    if (item.left_chg) begin
      if (left_prev_r) begin
        clk_mode_nxt = csc_clk_t'(clk_mode_r + 2'd1);
      end
      left_prev_nxt = item.left_lvl;
    end

    if (item.right_chg) begin
      if (right_prev_r) begin
        since_nxt = item.now_s;
        armed_nxt = 1'b1;
        if (clk_mode_nxt == CLK_ELAPSED) begin
          if (!running_r) begin
            running_nxt = 1'b1;
            start_nxt   = item.now_s;
          end else begin
            running_nxt = 1'b0;
            accum_nxt   = elapsed_sum;
          end
        end
      end
      if (item.right_lvl) begin
        armed_nxt = 1'b0;
      end
      right_prev_nxt = item.right_lvl;
    end else if (armed_r) begin
      if ((item.now_s - since_r) > {28'b0, cfg.hold_reset}) begin
        if (clk_mode_nxt == CLK_FLIGHT) begin
          flight_nxt = item.now_s;
        end else if (clk_mode_nxt == CLK_ELAPSED) begin
          accum_nxt   = 32'd0;
          running_nxt = 1'b0;
          watch_clr   = 1'b1;
        end
        armed_nxt = 1'b0;
      end
    end

    // temperature latch after the sample interval
    if ((item.now_s - last_temp_r) > {26'b0, cfg.temp_sample}) begin
      last_temp_nxt = item.now_s;
      held_nxt      = item.temp;
    end

    // seconds value that the clock row is built from
    case (clk_mode_nxt)
      CLK_UTC:    tval = {15'b0, item.utc_s} + 32'd30;
      CLK_LOCAL:  tval = {15'b0, item.loc_s} + 32'd30;
      CLK_FLIGHT: tval = item.now_s - flight_nxt;
      default:    tval = watch_clr ? 32'd0 : elapsed_sum;
    endcase
  end

  // Control state, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r       <= DISP_VOLTS;
      clk_mode_r   <= CLK_UTC;
      top_prev_r   <= 1'b1;
      left_prev_r  <= 1'b1;
      right_prev_r <= 1'b1;
      running_r    <= 1'b0;
      accum_r      <= '0;
      start_r      <= '0;
      armed_r      <= 1'b0;
      since_r      <= '0;
      flight_r     <= '0;
      last_temp_r  <= '0;
      held_r       <= '0;
    end else if (adv) begin
      disp_r       <= disp_nxt;
      clk_mode_r   <= clk_mode_nxt;
      top_prev_r   <= top_prev_nxt;
      left_prev_r  <= left_prev_nxt;
      right_prev_r <= right_prev_nxt;
      running_r    <= running_nxt;
      accum_r      <= accum_nxt;
      start_r      <= start_nxt;
      armed_r      <= armed_nxt;
      since_r      <= since_nxt;
      flight_r     <= flight_nxt;
      last_temp_r  <= last_temp_nxt;
      held_r       <= held_nxt;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (en) begin
      view_r.disp_mode <= disp_nxt;
      view_r.clk_mode  <= clk_mode_nxt;
      view_r.running   <= running_nxt;
      view_r.volts     <= item.volts;
      view_r.temp      <= held_nxt;
      view_r.tval      <= tval;
    end
  end

  assign view = view_r;

endmodule

[rtl/core/csc_fmt.sv]
// Digit formatter: four register stages of constant divides for the top row and clock row.
module csc_fmt (
  input  logic               clk,
  input  logic               en,
  input  csc_pkg::csc_view_t view,
  output csc_pkg::csc_res_t  res
);
  import csc_pkg::*;

  // stage 2
  csc_disp_t   disp_s2_r;
  csc_clk_t    clk_s2_r;
  logic        run_s2_r;
  logic [31:0] tval_s2_r;
  logic [26:0] q1_s2_r;
  logic [14:0] xa_s2_r;
  logic        neg_s2_r;
  logic        div_s2_r;
  // stage 3
  csc_disp_t   disp_s3_r;
  csc_clk_t    clk_s3_r;
  logic        run_s3_r;
  logic [5:0]  sec_s3_r;
  logic [26:0] q1_s3_r;
  logic [20:0] q2_s3_r;
  logic [19:0] q99_s3_r;
  logic [11:0] mag_s3_r;
  logic        minus_s3_r;
  // stage 4
  csc_disp_t   disp_s4_r;
  csc_clk_t    clk_s4_r;
  logic        run_s4_r;
  logic [5:0]  sec_s4_r;
  logic [5:0]  min60_s4_r;
  logic [6:0]  min99_s4_r;
  logic [20:0] q2_s4_r;
  logic [15:0] q24_s4_r;
  logic [7:0]  q10_s4_r;
  logic [3:0]  units_s4_r;
  logic        minus_s4_r;
  // output
  csc_res_t    res_r;

  // stage 2 logic: Fahrenheit numerator and magnitude
  logic signed [15:0] t16, f16, src;
  // stage 3 logic
  logic [31:0] mul60_q1, rem60;
  logic [11:0] mag_nxt;
  // stage 4 logic
  logic [26:0] mul60_q2, mul99_q99;
  logic [11:0] q10_w, ten_q10;
  // output logic
  logic [20:0] mul24_q24;
  logic [4:0]  hours;
  logic [6:0]  hi_val, lo_val;
  logic [7:0]  hi_bcd, lo_bcd;
  logic [11:0] hund_w;
  logic [7:0]  ten_hund;

  always_comb begin
    t16 = {{5{view.temp[10]}}, view.temp};
    f16 = 16'sd3200 + (t16 <<< 4) + (t16 <<< 1);
    case (view.disp_mode)
      DISP_FAHR: src = f16;
      DISP_CELS: src = t16;
      default:   src = $signed({6'b0, view.volts});
    endcase
  end

  always_comb begin
    mul60_q1 = ({5'b0, q1_s2_r} << 6) - ({5'b0, q1_s2_r} << 2);
    rem60    = tval_s2_r - mul60_q1;
    mag_nxt  = div_s2_r ? div10_15(xa_s2_r) : xa_s2_r[11:0];
  end

  always_comb begin
    mul60_q2  = ({6'b0, q2_s3_r} << 6) - ({6'b0, q2_s3_r} << 2);
    mul99_q99 = ({7'b0, q99_s3_r} << 6) + ({7'b0, q99_s3_r} << 5)
              + ({7'b0, q99_s3_r} << 1) + {7'b0, q99_s3_r};
    q10_w     = div10_15({3'b0, mag_s3_r});
    ten_q10   = (q10_w << 3) + (q10_w << 1);
  end

  // clock digits: HH MM, or MM SS in elapsed mode
  always_comb begin
    mul24_q24 = ({5'b0, q24_s4_r} << 4) + ({5'b0, q24_s4_r} << 3);
    hours     = 5'(q2_s4_r - mul24_q24);
    if (clk_s4_r == CLK_ELAPSED) begin
      hi_val = min99_s4_r;
      lo_val = {1'b0, sec_s4_r};
    end else begin
      hi_val = {2'b0, hours};
      lo_val = {1'b0, min60_s4_r};
    end
    hi_bcd   = bcd2(hi_val);
    lo_bcd   = bcd2(lo_val);
    hund_w   = div10_15({7'b0, q10_s4_r});
    ten_hund = ({3'b0, hund_w[4:0]} << 3) + ({3'b0, hund_w[4:0]} << 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 2
      disp_s2_r  <= view.disp_mode;
      clk_s2_r   <= view.clk_mode;
      run_s2_r   <= view.running;
      tval_s2_r  <= view.tval;
      q1_s2_r    <= div60_32(view.tval);
      neg_s2_r   <= src[15];
      xa_s2_r    <= src[15] ? 15'(-src) : src[14:0];
      div_s2_r   <= (view.disp_mode == DISP_FAHR);
      // stage 3
      disp_s3_r  <= disp_s2_r;
      clk_s3_r   <= clk_s2_r;
      run_s3_r   <= run_s2_r;
      sec_s3_r   <= rem60[5:0];
      q1_s3_r    <= q1_s2_r;
      q2_s3_r    <= div60_27(q1_s2_r);
      q99_s3_r   <= div99_27(q1_s2_r);
      mag_s3_r   <= mag_nxt;
      minus_s3_r <= neg_s2_r && (mag_nxt != 12'd0);
      // stage 4
      disp_s4_r  <= disp_s3_r;
      clk_s4_r   <= clk_s3_r;
      run_s4_r   <= run_s3_r;
      sec_s4_r   <= sec_s3_r;
      min60_s4_r <= 6'(q1_s3_r - mul60_q2);
      min99_s4_r <= 7'(q1_s3_r - mul99_q99);
      q2_s4_r    <= q2_s3_r;
      q24_s4_r   <= div24_21(q2_s3_r);
      q10_s4_r   <= q10_w[7:0];
      units_s4_r <= 4'(mag_s3_r - ten_q10);
      minus_s4_r <= minus_s3_r;
      // output register
      res_r.disp_mode    <= disp_s4_r;
      res_r.clk_mode     <= clk_s4_r;
      res_r.running      <= run_s4_r;
      res_r.top_hundreds <= hund_w[4:0];
      res_r.top_tens     <= 4'(q10_s4_r - ten_hund);
      res_r.top_units    <= units_s4_r;
      res_r.top_minus    <= minus_s4_r;
      res_r.digit_a      <= hi_bcd[7:4];
      res_r.digit_b      <= hi_bcd[3:0];
      res_r.digit_c      <= lo_bcd[7:4];
      res_r.digit_d      <= lo_bcd[3:0];
    end
  end

  assign res = res_r;

endmodule

[rtl/core/clock_stopwatch_controller.sv]
// Clock/stopwatch panel controller top level: handshake, input register, config, pipeline.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in_     | input     | in_valid/in_stall  | time, voltage, temperature, button bits
//   out_    | output    | out_valid/out_stall| mode codes, top-row digits, clock digits
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while no result waits under out_stall; each item passes from its
// input transfer to its result transfer through the input register, state pass and four formatter stages.
// The whole pipeline advances together and holds while a result waits under out_stall.
// Synchronous active-low reset clears the valid bits, resets the panel state and loads the config defaults.
// Config writes are always ready.
module clock_stopwatch_controller (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_now_seconds,
  input  logic [16:0]        in_utc_seconds,
  input  logic [16:0]        in_local_seconds,
  input  logic [9:0]         in_volts_tenths,
  input  logic signed [10:0] in_temp_c_tenths,
  input  logic               in_top_changed,
  input  logic               in_top_level,
  input  logic               in_left_changed,
  input  logic               in_left_level,
  input  logic               in_right_changed,
  input  logic               in_right_level,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_display_mode_out,
  output logic [1:0]         out_clock_mode_out,
  output logic [4:0]         out_top_hundreds,
  output logic [3:0]         out_top_tens,
  output logic [3:0]         out_top_units,
  output logic               out_top_minus,
  output logic [3:0]         out_clock_digit_a,
  output logic [3:0]         out_clock_digit_b,
  output logic [3:0]         out_clock_digit_c,
  output logic [3:0]         out_clock_digit_d,
  output logic               out_watch_running,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data
);
  import csc_pkg::*;

  logic      en;
  logic      accept;
  logic      adv;
  logic [4:0] vld_r;
  logic      out_valid_r;
  csc_item_t item_r;
  csc_cfg_t  cfg_r;
  csc_view_t view;
  csc_res_t  res;

  // pipeline moves unless a finished result is held by the sink
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;
  assign adv      = en && vld_r[0];

  // valid bits: input register, state pass, three formatter stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[3:0], accept};
      out_valid_r <= vld_r[4];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      item_r.now_s     <= in_now_seconds;
      item_r.utc_s     <= in_utc_seconds;
      item_r.loc_s     <= in_local_seconds;
      item_r.volts     <= in_volts_tenths;
      item_r.temp      <= in_temp_c_tenths;
      item_r.top_chg   <= in_top_changed;
      item_r.top_lvl   <= in_top_level;
      item_r.left_chg  <= in_left_changed;
      item_r.left_lvl  <= in_left_level;
      item_r.right_chg <= in_right_changed;
      item_r.right_lvl <= in_right_level;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_reset  <= HOLD_RESET_DEFAULT;
      cfg_r.temp_sample <= TEMP_SAMPLE_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOLD_RESET:  cfg_r.hold_reset  <= cfg_data[3:0];
        CFG_TEMP_SAMPLE: cfg_r.temp_sample <= cfg_data;
        default: ;
      endcase
    end
  end

  csc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .adv   (adv),
    .cfg   (cfg_r),
    .item  (item_r),
    .view  (view)
  );

  csc_fmt u_fmt (
    .clk  (clk),
    .en   (en),
    .view (view),
    .res  (res)
  );

  // result ports
  assign out_valid            = out_valid_r;
  assign out_display_mode_out = res.disp_mode;
  assign out_clock_mode_out   = res.clk_mode;
  assign out_top_hundreds     = res.top_hundreds;
  assign out_top_tens         = res.top_tens;
  assign out_top_units        = res.top_units;
  assign out_top_minus        = res.top_minus;
  assign out_clock_digit_a    = res.digit_a;
  assign out_clock_digit_b    = res.digit_b;
  assign out_clock_digit_c    = res.digit_c;
  assign out_clock_digit_d    = res.digit_d;
  assign out_watch_running    = res.running;

`ifndef NO_ASSERTIONS
  // an item leaving the last formatter stage lands in the output register
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && en) |=> out_valid_r)
    else $error("formatter result lost before output register");

  // minus only for a temperature mode
  a_minus_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_top_minus) |->
      (out_display_mode_out == DISP_FAHR || out_display_mode_out == DISP_CELS))
    else $error("minus flag in volts mode");

  // top-row low digits are decimal
  a_top_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_tens <= 4'd9 && out_top_units <= 4'd9))
    else $error("top row digit out of range");

  // time of day and flight: hours below 24, minutes below 60
  a_hhmm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clock_mode_out != CLK_ELAPSED) |->
      (out_clock_digit_a <= 4'd2 && out_clock_digit_c <= 4'd5 &&
       out_clock_digit_b <= 4'd9 && out_clock_digit_d <= 4'd9))
    else $error("clock digits out of range");

  // elapsed: seconds tens below 6, minutes below 99
  a_mmss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clock_mode_out == CLK_ELAPSED) |->
      (out_clock_digit_a <= 4'd9 && out_clock_digit_c <= 4'd5 &&
       out_clock_digit_b <= 4'd9 && out_clock_digit_d <= 4'd9))
    else $error("stopwatch digits out of range");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the clock/stopwatch panel controller.
module tb;
  import csc_pkg::*;

  // Button fields packed as {top_chg, top_lvl, left_chg, left_lvl, right_chg, right_lvl}
  localparam logic [5:0] BTN_IDLE   = 6'b010101;
  localparam logic [5:0] TOP_DOWN   = 6'b100101;
  localparam logic [5:0] TOP_UP     = 6'b110101;
  localparam logic [5:0] LEFT_DOWN  = 6'b011001;
  localparam logic [5:0] LEFT_UP    = 6'b011101;
  localparam logic [5:0] RIGHT_DOWN = 6'b010110;
  localparam logic [5:0] RIGHT_UP   = 6'b010111;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_now_seconds = '0;
  logic [16:0]        in_utc_seconds = '0;
  logic [16:0]        in_local_seconds = '0;
  logic [9:0]         in_volts_tenths = '0;
  logic signed [10:0] in_temp_c_tenths = '0;
  logic               in_top_changed = 1'b0;
  logic               in_top_level = 1'b1;
  logic               in_left_changed = 1'b0;
  logic               in_left_level = 1'b1;
  logic               in_right_changed = 1'b0;
  logic               in_right_level = 1'b1;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_display_mode_out;
  logic [1:0]         out_clock_mode_out;
  logic [4:0]         out_top_hundreds;
  logic [3:0]         out_top_tens;
  logic [3:0]         out_top_units;
  logic               out_top_minus;
  logic [3:0]         out_clock_digit_a;
  logic [3:0]         out_clock_digit_b;
  logic [3:0]         out_clock_digit_c;
  logic [3:0]         out_clock_digit_d;
  logic               out_watch_running;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_HOLD_RESET;
  logic [5:0]         cfg_data = '0;

  clock_stopwatch_controller dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_now_seconds       (in_now_seconds),
    .in_utc_seconds       (in_utc_seconds),
    .in_local_seconds     (in_local_seconds),
    .in_volts_tenths      (in_volts_tenths),
    .in_temp_c_tenths     (in_temp_c_tenths),
    .in_top_changed       (in_top_changed),
    .in_top_level         (in_top_level),
    .in_left_changed      (in_left_changed),
    .in_left_level        (in_left_level),
    .in_right_changed     (in_right_changed),
    .in_right_level       (in_right_level),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_display_mode_out (out_display_mode_out),
    .out_clock_mode_out   (out_clock_mode_out),
    .out_top_hundreds     (out_top_hundreds),
    .out_top_tens         (out_top_tens),
    .out_top_units        (out_top_units),
    .out_top_minus        (out_top_minus),
    .out_clock_digit_a    (out_clock_digit_a),
    .out_clock_digit_b    (out_clock_digit_b),
    .out_clock_digit_c    (out_clock_digit_c),
    .out_clock_digit_d    (out_clock_digit_d),
    .out_watch_running    (out_watch_running),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Panel state as the block should hold it
  csc_disp_t          view_disp    = DISP_VOLTS;
  csc_clk_t           view_clk     = CLK_UTC;
  logic               top_prev     = 1'b1;
  logic               left_prev    = 1'b1;
  logic               right_prev   = 1'b1;
  logic               watch_on     = 1'b0;
  logic [31:0]        watch_total  = '0;
  logic [31:0]        watch_from   = '0;
  logic               hold_pending = 1'b0;
  logic [31:0]        hold_from    = '0;
  logic [31:0]        flight_from  = '0;
  logic [31:0]        temp_stamp   = '0;
  logic signed [10:0] temp_held    = '0;
  logic [3:0]         hold_limit   = HOLD_RESET_DEFAULT;
  logic [5:0]         sample_gap   = TEMP_SAMPLE_DEFAULT;

  csc_res_t    shown_q[$];  // frames the panel should show, oldest first
  int          mismatch_cnt = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] wall_now = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic logic [15:0] hhmm_digits(input int unsigned mins);
    int unsigned h, m;
    h = (mins / 60) % 24;
    m = mins % 60;
    return {4'(h / 10), 4'(h % 10), 4'(m / 10), 4'(m % 10)};
  endfunction

  // Apply one panel update to the state copy and queue the frame it shows
  task automatic panel_predict(input csc_item_t u);
    logic [31:0] dt, secs;
    int          f;
    int unsigned mag, mins;
    csc_res_t    r;
    // button events
    if (u.top_chg) begin
      if (top_prev)
        view_disp = (view_disp >= DISP_CELS) ? DISP_VOLTS : csc_disp_t'(view_disp + 2'd1);
      top_prev = u.top_lvl;
    end
    if (u.left_chg) begin
      if (left_prev)
        view_clk = csc_clk_t'(view_clk + 2'd1);
      left_prev = u.left_lvl;
    end
    if (u.right_chg) begin
      if (right_prev) begin
        hold_from = u.now_s;
        hold_pending = 1'b1;
        if (view_clk == CLK_ELAPSED) begin
          if (!watch_on) begin
            watch_on = 1'b1;
            watch_from = u.now_s;
          end else begin
            watch_on = 1'b0;
            watch_total = watch_total + (u.now_s - watch_from);
          end
        end
      end
      if (u.right_lvl)
        hold_pending = 1'b0;
      right_prev = u.right_lvl;
    end else if (hold_pending) begin
      dt = u.now_s - hold_from;
      if (dt > 32'(hold_limit)) begin
        if (view_clk == CLK_FLIGHT) begin
          flight_from = u.now_s;
        end else if (view_clk == CLK_ELAPSED) begin
          watch_total = '0;
          watch_on = 1'b0;
        end
        hold_pending = 1'b0;
      end
    end
    // temperature latch
    dt = u.now_s - temp_stamp;
    if (dt > 32'(sample_gap)) begin
      temp_stamp = u.now_s;
      temp_held = u.temp;
    end
    // top row
    case (view_disp)
      DISP_FAHR: f = (3200 + 18 * int'(temp_held)) / 10;
      DISP_CELS: f = temp_held;
      default:   f = u.volts;
    endcase
    r.top_minus = (f < 0);
    mag = (f < 0) ? -f : f;
    r.top_hundreds = 5'(mag / 100);
    r.top_tens = 4'((mag / 10) % 10);
    r.top_units = 4'(mag % 10);
    // clock row
    case (view_clk)
      CLK_UTC: begin
        mins = (32'(u.utc_s) + 30) / 60;
        {r.digit_a, r.digit_b, r.digit_c, r.digit_d} = hhmm_digits(mins);
      end
      CLK_LOCAL: begin
        mins = (32'(u.loc_s) + 30) / 60;
        {r.digit_a, r.digit_b, r.digit_c, r.digit_d} = hhmm_digits(mins);
      end
      CLK_FLIGHT: begin
        dt = u.now_s - flight_from;
        {r.digit_a, r.digit_b, r.digit_c, r.digit_d} = hhmm_digits(dt / 60);
      end
      default: begin
        secs = watch_total;
        if (watch_on)
          secs = secs + (u.now_s - watch_from);
        mins = (secs / 60) % 99;
        {r.digit_a, r.digit_b, r.digit_c, r.digit_d} =
          {4'(mins / 10), 4'(mins % 10), 4'((secs % 60) / 10), 4'((secs % 60) % 10)};
      end
    endcase
    r.disp_mode = view_disp;
    r.clk_mode = view_clk;
    r.running = watch_on;
    shown_q.push_back(r);
  endtask

  // Send one update after any idle cycles; predict at the transfer
  task automatic send_update(input csc_item_t u);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_now_seconds <= u.now_s;
    in_utc_seconds <= u.utc_s;
    in_local_seconds <= u.loc_s;
    in_volts_tenths <= u.volts;
    in_temp_c_tenths <= u.temp;
    in_top_changed <= u.top_chg;
    in_top_level <= u.top_lvl;
    in_left_changed <= u.left_chg;
    in_left_level <= u.left_lvl;
    in_right_changed <= u.right_chg;
    in_right_level <= u.right_lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    panel_predict(u);
  endtask

  // Stop sending and wait for every queued frame to come out
  task automatic drain_pipeline();
    @(negedge clk) in_valid <= 1'b0;
    while (shown_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [5:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_HOLD_RESET)
      hold_limit = val[3:0];
    else
      sample_gap = val;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic csc_item_t panel_update(input logic [31:0] now, input int utc,
                                             input int loc, input int volts,
                                             input int temp, input logic [5:0] btn);
    csc_item_t u;
    u.now_s = now;
    u.utc_s = 17'(utc);
    u.loc_s = 17'(loc);
    u.volts = 10'(volts);
    u.temp = 11'(temp);
    {u.top_chg, u.top_lvl, u.left_chg, u.left_lvl, u.right_chg, u.right_lvl} = btn;
    return u;
  endfunction

  // {changed, level} for one button: mostly no change, else a real press or release, sometimes a tap
  function automatic logic [1:0] button_move(input logic prev, input int pct);
    if ($urandom_range(99) >= pct)
      return {1'b0, 1'($urandom)};
    return {1'b1, prev ? 1'($urandom_range(9) < 3) : 1'b1};
  endfunction

  // Random updates: mostly slowly advancing time and proper press/release pairs
  task automatic run_random_updates(input int count);
    csc_item_t u;
    int        r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 55)      wall_now = wall_now + $urandom_range(2);
      else if (r < 85) wall_now = wall_now + $urandom_range(20, 3);
      else if (r < 95) wall_now = wall_now + $urandom_range(400, 21);
      else if (r < 98) wall_now = $urandom;
      else             wall_now = wall_now - $urandom_range(60);
      u.now_s = wall_now;
      u.utc_s = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(86399));
      u.loc_s = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(86399));
      u.volts = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(999));
      u.temp = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1998) - 999);
      if ($urandom_range(9) == 0) begin
        // noise: arbitrary change/level bits
        {u.top_chg, u.top_lvl, u.left_chg, u.left_lvl, u.right_chg, u.right_lvl} =
          6'($urandom);
      end else begin
        {u.top_chg, u.top_lvl} = button_move(top_prev, 8);
        {u.left_chg, u.left_lvl} = button_move(left_prev, 7);
        {u.right_chg, u.right_lvl} = button_move(right_prev, 15);
      end
      send_update(u);
    end
  endtask

  // Every mode, press/release corner cases, holds, sampling and time extremes
  task automatic test_directed_cases();
    send_update(panel_update(0, 0, 131071, 0, -1024, BTN_IDLE));
    send_update(panel_update(10, 131071, 0, 1023, 1023, BTN_IDLE));
    send_update(panel_update(11, 43199, 43170, 999, -999, TOP_DOWN));
    send_update(panel_update(12, 86399, 29, 500, 0, TOP_UP));
    // release-level report from released state is still a press
    send_update(panel_update(20, 30, 89, 1, -1024, TOP_UP));
    send_update(panel_update(21, 29, 90, 99, 1, TOP_DOWN));
    // repeated pressed level is not a press
    send_update(panel_update(22, 59, 3599, 100, -1, TOP_DOWN));
    send_update(panel_update(23, 3570, 3629, 909, 5, TOP_UP));
    send_update(panel_update(30, 65535, 65536, 1000, -999, TOP_UP));
    send_update(panel_update(31, 1, 2, 3, 999, LEFT_UP));
    send_update(panel_update(32, 4, 5, 6, -5, LEFT_DOWN));
    // flight timer reset by a long hold
    send_update(panel_update(33, 7, 8, 9, 10, RIGHT_DOWN));
    send_update(panel_update(34, 7, 8, 9, 10, BTN_IDLE));
    send_update(panel_update(36, 7, 8, 9, 10, BTN_IDLE));
    send_update(panel_update(4000, 7, 8, 9, 10, RIGHT_UP));
    send_update(panel_update(4001, 7, 8, 9, 10, LEFT_UP));
    send_update(panel_update(4002, 7, 8, 9, 10, LEFT_UP));
    // stopwatch start, stop, hold clear
    send_update(panel_update(4003, 0, 0, 0, 0, RIGHT_UP));
    send_update(panel_update(10000, 0, 0, 0, 0, BTN_IDLE));
    send_update(panel_update(10003, 0, 0, 0, 0, RIGHT_DOWN));
    send_update(panel_update(10010, 0, 0, 0, 0, BTN_IDLE));
    send_update(panel_update(10011, 0, 0, 0, 0, RIGHT_UP));
    send_update(panel_update(10012, 0, 0, 0, 0, RIGHT_UP));
    // time running backwards, then the top of the counter
    send_update(panel_update(5, 0, 0, 0, 0, BTN_IDLE));
    send_update(panel_update(32'hFFFF_FFFF, 0, 0, 0, 0, RIGHT_DOWN));
    send_update(panel_update(32'hFFFF_FFFF, 131071, 131071, 1023, -1, LEFT_UP));
    wall_now = 32'hFFFF_FFFF;
  endtask

  task automatic test_fast_hold_and_sample();
    drain_pipeline();
    write_cfg(CFG_HOLD_RESET, 6'd0);
    write_cfg(CFG_TEMP_SAMPLE, 6'd0);
    run_random_updates(530);
  endtask

  task automatic test_slow_hold_and_sample();
    drain_pipeline();
    send_idle_pct = 52;
    stall_pct = 13;
    write_cfg(CFG_HOLD_RESET, 6'd15);
    write_cfg(CFG_TEMP_SAMPLE, 6'd63);
    run_random_updates(530);
  endtask

  task automatic test_back_to_back();
    drain_pipeline();
    send_idle_pct = 0;
    stall_pct = 0;
    write_cfg(CFG_HOLD_RESET, 6'($urandom_range(14, 1)));
    write_cfg(CFG_TEMP_SAMPLE, 6'($urandom_range(62, 1)));
    run_random_updates(530);
  endtask

  // Result receiver stalls at random
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Compare each result transfer with the oldest queued frame
  always @(posedge clk) begin
    csc_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (shown_q.size() == 0) begin
        report_mismatch("result transfer with nothing queued", 1, 0);
      end else begin
        want = shown_q.pop_front();
        if (out_display_mode_out != want.disp_mode)
          report_mismatch("display_mode_out", out_display_mode_out, want.disp_mode);
        if (out_clock_mode_out != want.clk_mode)
          report_mismatch("clock_mode_out", out_clock_mode_out, want.clk_mode);
        if (out_top_hundreds != want.top_hundreds)
          report_mismatch("top_hundreds", out_top_hundreds, want.top_hundreds);
        if (out_top_tens != want.top_tens)
          report_mismatch("top_tens", out_top_tens, want.top_tens);
        if (out_top_units != want.top_units)
          report_mismatch("top_units", out_top_units, want.top_units);
        if (out_top_minus != want.top_minus)
          report_mismatch("top_minus", out_top_minus, want.top_minus);
        if (out_clock_digit_a != want.digit_a)
          report_mismatch("clock_digit_a", out_clock_digit_a, want.digit_a);
        if (out_clock_digit_b != want.digit_b)
          report_mismatch("clock_digit_b", out_clock_digit_b, want.digit_b);
        if (out_clock_digit_c != want.digit_c)
          report_mismatch("clock_digit_c", out_clock_digit_c, want.digit_c);
        if (out_clock_digit_d != want.digit_d)
          report_mismatch("clock_digit_d", out_clock_digit_d, want.digit_d);
        if (out_watch_running != want.running)
          report_mismatch("watch_running", out_watch_running, want.running);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    send_idle_pct = 13;
    stall_pct = 52;
    test_directed_cases();
    test_fast_hold_and_sample();
    test_slow_hold_and_sample();
    test_back_to_back();
    drain_pipeline();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
